>>> hw/rtl/arp_cache_next_hop_resolver_core_macros.svh
// assertion helpers for the resolver core
`ifndef ARP_CACHE_NEXT_HOP_RESOLVER_CORE_MACROS_SVH
`define ARP_CACHE_NEXT_HOP_RESOLVER_CORE_MACROS_SVH

// same-cycle implication, silent while reset is high
`define ARPNH_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("arpnh assertion failed");

// next-cycle implication, silent while reset is high
`define ARPNH_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("arpnh assertion failed");

`endif

>>> hw/rtl/arpnh_pkg.sv
package arpnh_pkg;

   localparam int unsigned IP_W     = 32;
   localparam int unsigned MAC_W    = 48;
   localparam int unsigned SLOT_W   = 4;
   localparam int unsigned CSR_IDX_W = 2;

   typedef logic [IP_W-1:0]      ip_type;
   typedef logic [MAC_W-1:0]     mac_type;
   typedef logic [SLOT_W-1:0]    slot_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   typedef enum logic [2:0] {
      ACT_UPDATED = 3'd0,
      ACT_FILLED  = 3'd1,
      ACT_EVICTED = 3'd2,
      ACT_HIT     = 3'd3,
      ACT_MISS    = 3'd4
   } action_type;

   typedef enum logic {
      CMD_ADD     = 1'b0,
      CMD_RESOLVE = 1'b1
   } cmd_type;

   localparam csr_idx_type CSR_OWN_IP      = 2'd0;
   localparam csr_idx_type CSR_SUBNET_MASK = 2'd1;
   localparam csr_idx_type CSR_GATEWAY_IP  = 2'd2;

   localparam ip_type OWN_IP_RST      = 32'h0A00_020F;
   localparam ip_type SUBNET_MASK_RST = 32'hFFFF_FF00;
   localparam ip_type GATEWAY_IP_RST  = 32'h0A00_0202;

endpackage

>>> hw/rtl/arp_cache_next_hop_resolver_core.sv
// arp cache with subnet next-hop selection, one result item per input item
// an accepted item is answered when the scan stops at slot k: the read of slot k is
//   registered, then checked, and the result is registered with the strobe
// throughput: one item at a time, set by the single read port of the binding memory
//   scanned one entry a cycle; start is taken again in the cycle of the strobe
// reset clears the valid bits and loads the register defaults at once; the receiver never stalls
module arp_cache_next_hop_resolver_core #(
   parameter int unsigned ENTRIES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // input item
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_cmd,
   input  arpnh_pkg::ip_type      req_ip_addr,
   input  arpnh_pkg::mac_type     req_new_mac,
   // result item, one cycle wide
   output logic                   rsp_strobe,
   output logic [2:0]             rsp_action,
   output arpnh_pkg::slot_type    rsp_slot,
   output arpnh_pkg::ip_type      rsp_hop_ip,
   output arpnh_pkg::mac_type     rsp_found_mac,
   // register writes
   input  logic                   csr_we,
   input  arpnh_pkg::csr_idx_type csr_index,
   input  arpnh_pkg::ip_type      csr_wdata
);
   import arpnh_pkg::*;

`include "arp_cache_next_hop_resolver_core_macros.svh"

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CNT_W = IDX_W + 1;
   localparam int unsigned ROW_W = IP_W + MAC_W;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   localparam idx_type LAST_IDX    = IDX_W'(ENTRIES - 1);
   localparam cnt_type ENTRIES_CNT = CNT_W'(ENTRIES);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // slot port carries the low four bits of the index
   function automatic slot_type idx_to_slot(input idx_type idx);
      logic [IDX_W+SLOT_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, idx};
      return wide[SLOT_W-1:0];
   endfunction

   // register file
   ip_type own_ip_ff, subnet_mask_ff, gateway_ip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff      <= OWN_IP_RST;
         subnet_mask_ff <= SUBNET_MASK_RST;
         gateway_ip_ff  <= GATEWAY_IP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_IP:      own_ip_ff      <= csr_wdata;
            CSR_SUBNET_MASK: subnet_mask_ff <= csr_wdata;
            CSR_GATEWAY_IP:  gateway_ip_ff  <= csr_wdata;
            default: ; // index beyond the list is dropped
         endcase
      end
   end

   // binding memory: {ip, mac} per entry, one write and one registered read port
   logic [ROW_W-1:0] bind_mem [ENTRIES];
   logic [ROW_W-1:0] rd_data_ff;
   logic             rd_en;
   idx_type          rd_addr;
   logic             wr_en;
   idx_type          wr_addr;
   logic [ROW_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bind_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= bind_mem[rd_addr];
      end
   end

   ip_type  rd_ip;
   mac_type rd_mac;
   assign rd_ip  = rd_data_ff[ROW_W-1:MAC_W];
   assign rd_mac = rd_data_ff[MAC_W-1:0];

   // control and payload registers
   state_type            state_ff, state_in;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   cnt_type              cnt_ff, cnt_in;       // next entry to read
   logic                 rd_pend_ff, rd_pend_in; // read data in flight
   idx_type              rd_idx_ff, rd_idx_in;
   logic                 free_ok_ff, free_ok_in; // a free slot seen so far
   idx_type              free_idx_ff, free_idx_in;
   logic                 cmd_ff, cmd_in;
   ip_type               hop_ff, hop_in;
   mac_type              mac_ff, mac_in;
   logic                 strobe_ff, strobe_in;
   logic [2:0]           action_ff, action_in;
   slot_type             slot_ff, slot_in;
   ip_type               out_hop_ff, out_hop_in;
   mac_type              out_mac_ff, out_mac_in;

   logic    accept;
   logic    local_net;
   logic    cur_valid;
   logic    match;
   logic    have_free;
   idx_type free_target;

   assign accept    = start && (state_ff == ST_IDLE);
   assign local_net = ((req_ip_addr & subnet_mask_ff) == (own_ip_ff & subnet_mask_ff));
   assign cur_valid = valid_ff[rd_idx_ff];
   assign match     = cur_valid && (rd_ip == hop_ff);
   // the entry just read may itself be the first free one
   assign have_free   = free_ok_ff || !cur_valid;
   assign free_target = free_ok_ff ? free_idx_ff : rd_idx_ff;

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      cnt_in      = cnt_ff;
      rd_pend_in  = 1'b0;
      rd_idx_in   = rd_idx_ff;
      free_ok_in  = free_ok_ff;
      free_idx_in = free_idx_ff;
      cmd_in      = cmd_ff;
      hop_in      = hop_ff;
      mac_in      = mac_ff;
      strobe_in   = 1'b0;
      action_in   = action_ff;
      slot_in     = slot_ff;
      out_hop_in  = out_hop_ff;
      out_mac_in  = out_mac_ff;
      rd_en       = 1'b0;
      rd_addr     = cnt_ff[IDX_W-1:0];
      wr_en       = 1'b0;
      wr_addr     = rd_idx_ff;
      wr_data     = {hop_ff, mac_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in     = req_cmd;
               mac_in     = req_new_mac;
               // resolve picks the destination on the local subnet, else the gateway
               hop_in     = ((req_cmd == CMD_RESOLVE) && !local_net) ? gateway_ip_ff
                                                                     : req_ip_addr;
               cnt_in     = '0;
               free_ok_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one read a cycle until every entry has been requested or the scan ends
            if (cnt_ff < ENTRIES_CNT) begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in  = cnt_ff[IDX_W-1:0];
               cnt_in     = cnt_ff + 1'b1;
            end
            if (rd_pend_ff) begin
               if (!cur_valid && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (match) begin
                  // lowest matching entry ends the scan
                  state_in   = ST_IDLE;
                  strobe_in  = 1'b1;
                  slot_in    = idx_to_slot(rd_idx_ff);
                  out_hop_in = hop_ff;
                  if (cmd_ff == CMD_ADD) begin
                     wr_en      = 1'b1;
                     action_in  = ACT_UPDATED;
                     out_mac_in = '0;
                  end else begin
                     action_in  = ACT_HIT;
                     out_mac_in = rd_mac;
                  end
               end else if (rd_idx_ff == LAST_IDX) begin
                  state_in   = ST_IDLE;
                  strobe_in  = 1'b1;
                  out_hop_in = hop_ff;
                  out_mac_in = '0;
                  if (cmd_ff == CMD_ADD) begin
                     // fill the first free slot, or evict slot zero when full
                     wr_en    = 1'b1;
                     wr_addr  = have_free ? free_target : '0;
                     valid_in[wr_addr] = 1'b1;
                     action_in = have_free ? ACT_FILLED : ACT_EVICTED;
                     slot_in   = idx_to_slot(wr_addr);
                  end else begin
                     action_in = ACT_MISS;
                     slot_in   = '0;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         rd_pend_ff <= 1'b0;
         strobe_ff  <= 1'b0;
         cnt_ff     <= '0;
         free_ok_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         rd_pend_ff <= rd_pend_in;
         strobe_ff  <= strobe_in;
         cnt_ff     <= cnt_in;
         free_ok_ff <= free_ok_in;
      end
      rd_idx_ff   <= rd_idx_in;
      free_idx_ff <= free_idx_in;
      cmd_ff      <= cmd_in;
      hop_ff      <= hop_in;
      mac_ff      <= mac_in;
      action_ff   <= action_in;
      slot_ff     <= slot_in;
      out_hop_ff  <= out_hop_in;
      out_mac_ff  <= out_mac_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_action    = action_ff;
   assign rsp_slot      = slot_ff;
   assign rsp_hop_ip    = out_hop_ff;
   assign rsp_found_mac = out_mac_ff;

   // checks
   `ARPNH_ASSERT_NXT(a_accept_busy, clock, reset, accept, busy)
   `ARPNH_ASSERT_NXT(a_strobe_single, clock, reset, strobe_ff, !strobe_ff)
   `ARPNH_ASSERT_IMP(a_miss_clean, clock, reset, strobe_ff && (action_ff == ACT_MISS),
      (slot_ff == '0) && (out_mac_ff == '0))
   `ARPNH_ASSERT_IMP(a_add_no_mac, clock, reset,
      strobe_ff && ((action_ff == ACT_UPDATED) || (action_ff == ACT_FILLED) ||
      (action_ff == ACT_EVICTED)), out_mac_ff == '0)
   `ARPNH_ASSERT_IMP(a_scan_bound, clock, reset, state_ff == ST_SCAN, cnt_ff <= ENTRIES_CNT)

endmodule

>>> tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import arpnh_pkg::*;

   localparam int ENTRY_COUNT = 16;
   // index past the last register, writes to it must be dropped
   localparam csr_idx_type CSR_SPARE = 2'd3;

   // one expected result item
   typedef struct {
      action_type action;
      slot_type   slot;
      ip_type     hop_ip;
      mac_type    found_mac;
   } answer_type;

   // mirror of the binding table and registers, plus the answers still owed
   class binding_scoreboard;
      ip_type  own_ip;
      ip_type  net_mask;
      ip_type  gw_ip;
      bit      slot_used [ENTRY_COUNT];
      ip_type  slot_ip   [ENTRY_COUNT];
      mac_type slot_mac  [ENTRY_COUNT];
      answer_type answers[$];
      int      errors, adds, resolves, hits, misses, fills, updates, evictions;

      function void clear();
         own_ip   = OWN_IP_RST;
         net_mask = SUBNET_MASK_RST;
         gw_ip    = GATEWAY_IP_RST;
         for (int k = 0; k < ENTRY_COUNT; k++) begin
            slot_used[k] = 1'b0;
            slot_ip[k]   = '0;
            slot_mac[k]  = '0;
         end
         answers.delete();
      endfunction

      function void write_reg(csr_idx_type idx, ip_type data);
         case (idx)
            CSR_OWN_IP:      own_ip   = data;
            CSR_SUBNET_MASK: net_mask = data;
            CSR_GATEWAY_IP:  gw_ip    = data;
            default: ;
         endcase
      endfunction

      // lowest valid slot holding ip, -1 if none
      function int find_slot(ip_type ip);
         for (int k = 0; k < ENTRY_COUNT; k++)
            if (slot_used[k] && slot_ip[k] == ip) return k;
         return -1;
      endfunction

      function void note_request(cmd_type cmd, ip_type ip, mac_type mac);
         answer_type ans;
         int      k;
         ans.slot      = '0;
         ans.found_mac = '0;
         if (cmd == CMD_ADD) begin
            adds++;
            ans.hop_ip = ip;
            k = find_slot(ip);
            if (k >= 0) begin
               slot_mac[k] = mac;
               ans.action  = ACT_UPDATED;
               updates++;
            end else begin
               k = 0;
               while (k < ENTRY_COUNT && slot_used[k]) k++;
               if (k < ENTRY_COUNT) begin
                  ans.action = ACT_FILLED;
                  fills++;
               end else begin
                  k = 0;
                  ans.action = ACT_EVICTED;
                  evictions++;
               end
               slot_used[k] = 1'b1;
               slot_ip[k]   = ip;
               slot_mac[k]  = mac;
            end
            ans.slot = slot_type'(k);
         end else begin
            resolves++;
            ans.hop_ip = ((ip & net_mask) == (own_ip & net_mask)) ? ip : gw_ip;
            k = find_slot(ans.hop_ip);
            if (k >= 0) begin
               ans.action    = ACT_HIT;
               ans.slot      = slot_type'(k);
               ans.found_mac = slot_mac[k];
               hits++;
            end else begin
               ans.action = ACT_MISS;
               misses++;
            end
         end
         answers.push_back(ans);
      endfunction

      function void check_response(logic [2:0] act, slot_type slot, ip_type hop,
                                   mac_type fmac);
         answer_type ans;
         if (answers.size() == 0) begin
            $error("result item with nothing expected: action %0d slot %0d", act, slot);
            errors++;
            return;
         end
         ans = answers.pop_front();
         if (act !== ans.action) begin
            $error("action: expected %0d, got %0d", ans.action, act);
            errors++;
         end
         if (slot !== ans.slot) begin
            $error("slot: expected %0d, got %0d", ans.slot, slot);
            errors++;
         end
         if (hop !== ans.hop_ip) begin
            $error("next hop: expected %h, got %h", ans.hop_ip, hop);
            errors++;
         end
         if (fmac !== ans.found_mac) begin
            $error("found_mac: expected %h, got %h", ans.found_mac, fmac);
            errors++;
         end
      endfunction

      function int outstanding();
         return answers.size();
      endfunction
   endclass

   // clock, reset and block inputs, all known from time zero
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        start       = 1'b0;
   logic        req_cmd     = 1'b0;
   ip_type      req_ip_addr = '0;
   mac_type     req_new_mac = '0;
   logic        csr_we      = 1'b0;
   csr_idx_type csr_index   = '0;
   ip_type      csr_wdata   = '0;

   logic        busy;
   logic        rsp_strobe;
   logic [2:0]  rsp_action;
   slot_type    rsp_slot;
   ip_type      rsp_hop_ip;
   mac_type     rsp_found_mac;

   binding_scoreboard sb;
   bit     idle_on = 1'b1;
   int     settings = 1;
   // current register values, used to aim addresses at the local subnet
   ip_type cur_own  = OWN_IP_RST;
   ip_type cur_mask = SUBNET_MASK_RST;
   ip_type cur_gw   = GATEWAY_IP_RST;

   arp_cache_next_hop_resolver_core #(
      .ENTRIES(ENTRY_COUNT)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_ip_addr   (req_ip_addr),
      .req_new_mac   (req_new_mac),
      .rsp_strobe    (rsp_strobe),
      .rsp_action    (rsp_action),
      .rsp_slot      (rsp_slot),
      .rsp_hop_ip    (rsp_hop_ip),
      .rsp_found_mac (rsp_found_mac),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #10 clock = ~clock;

   // monitor: everything is sampled at the edge, before this step's updates land
   always @(posedge clock) begin
      if (!reset) begin
         // results first, so an item accepted in the strobe cycle queues behind
         if (rsp_strobe)
            sb.check_response(rsp_action, rsp_slot, rsp_hop_ip, rsp_found_mac);
         if (csr_we)
            sb.write_reg(csr_index, csr_wdata);
         if (start && !busy)
            sb.note_request(cmd_type'(req_cmd), req_ip_addr, req_new_mac);
      end
   end

   // present one item and return at the edge where it is taken; start stays high
   // so a back-to-back item follows without a dip
   task automatic send_item(input cmd_type cmd, input ip_type ip, input mac_type mac);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(99) < 12) gap = $urandom_range(24, 1);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_cmd     <= cmd;
      req_ip_addr <= ip;
      req_new_mac <= mac;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // hold the sender off until every result item owed has come back
   task automatic drain_answers();
      start <= 1'b0;
      // one edge first so the last accepted item is surely on the queue
      @(posedge clock);
      while (sb.outstanding() > 0) @(posedge clock);
   endtask

   task automatic put_reg(input csr_idx_type idx, input ip_type data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // only called while the block is idle
   task automatic configure(input ip_type own, input ip_type mask, input ip_type gw,
                            input bit poke_spare);
      put_reg(CSR_OWN_IP, own);
      put_reg(CSR_SUBNET_MASK, mask);
      put_reg(CSR_GATEWAY_IP, gw);
      // a write past the last register must leave the others alone
      if (poke_spare) put_reg(CSR_SPARE, $urandom());
      csr_we <= 1'b0;
      @(posedge clock);
      cur_own  = own;
      cur_mask = mask;
      cur_gw   = gw;
      settings++;
   endtask

   function automatic mac_type any_mac();
      return {16'($urandom()), 32'($urandom())};
   endfunction

   initial begin
      ip_type  pool [20];
      ip_type  ip, own, mask, gw;
      cmd_type cmd;
      int      r, prefix;

      sb = new;
      sb.clear();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table under the default registers
      send_item(CMD_RESOLVE, 32'h0A00_0202, '0);            // on-subnet miss
      send_item(CMD_RESOLVE, 32'hFFFF_FFFF, '1);            // off-subnet, gateway misses
      send_item(CMD_ADD,     32'h0A00_0202, 48'hFFFF_FFFF_FFFF);
      send_item(CMD_RESOLVE, 32'h0808_0808, '0);            // via gateway, hit
      send_item(CMD_RESOLVE, 32'h0000_0000, '0);            // via gateway, hit
      send_item(CMD_ADD,     32'h0A00_024D, 48'h0);
      send_item(CMD_RESOLVE, 32'h0A00_024D, '1);            // local hit, zero mac
      send_item(CMD_ADD,     32'h0A00_024D, 48'hA5A5_A5A5_A5A5);  // update in place
      send_item(CMD_RESOLVE, 32'h0A00_0263, '0);            // local miss
      send_item(CMD_ADD,     32'h0000_0000, 48'h5A5A_5A5A_5A5A);
      send_item(CMD_ADD,     32'hFFFF_FFFF, 48'h0123_4567_89AB);
      // fill the remaining slots, then one more add takes slot 0
      for (int k = 4; k < ENTRY_COUNT; k++)
         send_item(CMD_ADD, 32'h0A00_0260 + k, any_mac());
      send_item(CMD_ADD,     32'hC0A8_0001, 48'hFEDC_BA98_7654);
      send_item(CMD_RESOLVE, 32'h0808_0808, '0);            // gateway entry gone, miss
      drain_answers();

      // random phases, each under its own register setting
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin own = $urandom(); mask = '0; gw = $urandom(); end
            1: begin own = '0; mask = '1; gw = '1; end
            2: begin own = '1; mask = '1; gw = '0; end
            3: begin own = OWN_IP_RST; mask = SUBNET_MASK_RST; gw = GATEWAY_IP_RST; end
            default: begin
               prefix = $urandom_range(32);
               mask   = (prefix == 0) ? '0 : ~(32'hFFFF_FFFF >> prefix);
               own    = $urandom();
               gw     = ($urandom_range(1)) ? ((own & mask) | ($urandom() & ~mask))
                                            : $urandom();
            end
         endcase
         configure(own, mask, gw, (ph % 2) == 0);
         // one phase runs flat out with no idling at all
         idle_on = (ph != 3);

         // a small address pool makes hits, updates and slot-0 evictions common
         pool[0] = cur_gw;
         pool[1] = cur_own;
         for (int k = 2; k < 14; k++) pool[k] = (cur_own & cur_mask) | ($urandom() & ~cur_mask);
         for (int k = 14; k < 20; k++) pool[k] = $urandom();

         for (int n = 0; n < 135; n++) begin
            r = $urandom_range(99);
            if (r < 45) begin
               cmd = CMD_ADD;
               ip  = ($urandom_range(99) < 85) ? pool[$urandom_range(19)] : $urandom();
            end else begin
               cmd = CMD_RESOLVE;
               r   = $urandom_range(99);
               if (r < 55)      ip = pool[$urandom_range(19)];
               else if (r < 80) ip = (cur_own & cur_mask) | ($urandom() & ~cur_mask);
               else             ip = $urandom();
            end
            send_item(cmd, ip, any_mac());
         end
         drain_answers();
      end

      // tail: let any stray result item show itself
      repeat (24) @(posedge clock);
      if (sb.outstanding() > 0) begin
         $error("%0d result items never arrived", sb.outstanding());
         sb.errors++;
      end

      $display("testbench: %0d adds and %0d resolves under %0d register settings",
               sb.adds, sb.resolves, settings);
      $display("testbench: %0d hits, %0d misses, %0d fills, %0d updates, %0d slot 0 evictions",
               sb.hits, sb.misses, sb.fills, sb.updates, sb.evictions);
      if (sb.errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #8000000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
